// ----- sv/rbst_pkg.sv -----
package rbst_pkg;

    localparam int VALUE_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;

    typedef struct packed {
        logic first;
        logic last;
        logic dir_zero;
        logic zero_miss;
        logic lo_qneg;
        logic hi_qneg;
    } rbst_flags_t;

    localparam int FLAGS_W = $bits(rbst_flags_t);

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_ORDER,
        BK_NARROW,
        BK_CHECK
    } bk_state_t;

endpackage

// ----- sv/ray_box_slab_test_unit.sv -----
// Ray against axis-aligned box slab test, signed fixed point
// (VALUE_WIDTH bits, FRACTION_BITS fractional; Q16.16 by default).
// Input channel: push / full. One transfer per axis of a test; first_axis
// loads interval_start / interval_end, last_axis asks for the hit result.
// Result channel: empty / pop. hit is valid while empty is low and leaves
// on a pop transfer; at most one result waits in the output register.
// A two-entry queue sits between the classify front and the divide back,
// so up to two axes are taken while the back is busy.
// Per axis the back runs both slab quotients in two radix-2 dividers in
// lockstep, VALUE_WIDTH + FRACTION_BITS steps, then orders, narrows and
// checks the interval; a zero direction skips the dividers. The result is
// on the ports the cycle after the check stage of the last axis.
// When the receiver stalls, the back holds in its check stage on a last
// axis until the output register frees; the queue then fills and full
// rises. Reset clears the queue, the output register and the running
// interval (0..0, empty, so an axis without first_axis misses).
module ray_box_slab_test_unit
    import rbst_pkg::*;
#(
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          first_axis,
    input  logic                          last_axis,
    input  logic signed [VALUE_WIDTH-1:0] box_low,
    input  logic signed [VALUE_WIDTH-1:0] box_high,
    input  logic signed [VALUE_WIDTH-1:0] ray_origin,
    input  logic signed [VALUE_WIDTH-1:0] ray_dir,
    input  logic signed [VALUE_WIDTH-1:0] interval_start,
    input  logic signed [VALUE_WIDTH-1:0] interval_end,
    output logic                          empty,
    input  logic                          pop,
    output logic                          hit
);

    localparam int W      = VALUE_WIDTH;
    localparam int REC_W  = FLAGS_W + 5 * W;

    rbst_flags_t         f_flags, q_flags;
    logic [W-1:0]        f_nmag_lo, f_nmag_hi, f_dmag;
    logic [W-1:0]        q_nmag_lo, q_nmag_hi, q_dmag;
    logic signed [W-1:0] q_istart, q_iend;
    logic [REC_W-1:0]    wr_rec, rd_rec;
    logic                q_valid, q_pop;
    logic                res_valid;

    rbst_front #(.W(W)) u_front (
        .first_axis (first_axis),
        .last_axis  (last_axis),
        .box_low    (box_low),
        .box_high   (box_high),
        .ray_origin (ray_origin),
        .ray_dir    (ray_dir),
        .flags      (f_flags),
        .nmag_lo    (f_nmag_lo),
        .nmag_hi    (f_nmag_hi),
        .dmag       (f_dmag)
    );

    assign wr_rec = {f_flags, f_nmag_lo, f_nmag_hi, f_dmag, interval_start, interval_end};

    rbst_fifo #(.DATA_W(REC_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (wr_rec),
        .rd_en   (q_pop),
        .rd_data (rd_rec),
        .valid   (q_valid),
        .full    (full)
    );

    assign {q_flags, q_nmag_lo, q_nmag_hi, q_dmag, q_istart, q_iend} = rd_rec;

    rbst_back #(.W(W), .F(FRACTION_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_flags   (q_flags),
        .q_nmag_lo (q_nmag_lo),
        .q_nmag_hi (q_nmag_hi),
        .q_dmag    (q_dmag),
        .q_istart  (q_istart),
        .q_iend    (q_iend),
        .q_pop     (q_pop),
        .res_pop   (pop && res_valid),
        .res_valid (res_valid),
        .res_hit   (hit)
    );

    assign empty = !res_valid;

endmodule

// ----- sv/rbst_fifo.sv -----
module rbst_fifo
    import rbst_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              valid,
    output logic              full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign valid   = (cnt_reg != '0);
    assign full    = (cnt_reg == CNT_FULL);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- sv/rbst_front.sv -----
module rbst_front
    import rbst_pkg::*;
#(
    parameter int W = VALUE_WIDTH_DEF
)
(
    input  logic                first_axis,
    input  logic                last_axis,
    input  logic signed [W-1:0] box_low,
    input  logic signed [W-1:0] box_high,
    input  logic signed [W-1:0] ray_origin,
    input  logic signed [W-1:0] ray_dir,
    output rbst_flags_t         flags,
    output logic [W-1:0]        nmag_lo,
    output logic [W-1:0]        nmag_hi,
    output logic [W-1:0]        dmag
);

    logic signed [W:0]   lo_x, hi_x, org_x;
    logic signed [W:0]   lo_d, lo_nd, hi_d, hi_nd;
    logic                dneg;
    logic                lo_le_hi;
    logic signed [W-1:0] slab_min, slab_max;

    always_comb
    begin
        lo_x  = {box_low[W-1], box_low};
        hi_x  = {box_high[W-1], box_high};
        org_x = {ray_origin[W-1], ray_origin};
        lo_d  = lo_x - org_x;
        lo_nd = org_x - lo_x;
        hi_d  = hi_x - org_x;
        hi_nd = org_x - hi_x;
        dneg  = ray_dir[W-1];

        nmag_lo = lo_d[W] ? lo_nd[W-1:0] : lo_d[W-1:0];
        nmag_hi = hi_d[W] ? hi_nd[W-1:0] : hi_d[W-1:0];
        dmag    = dneg ? (W)'(-ray_dir) : ray_dir;

        lo_le_hi = (box_low <= box_high);
        slab_min = lo_le_hi ? box_low : box_high;
        slab_max = lo_le_hi ? box_high : box_low;

        flags.first     = first_axis;
        flags.last      = last_axis;
        flags.dir_zero  = (ray_dir == '0);
        flags.zero_miss = (ray_origin < slab_min) || (slab_max < ray_origin);
        flags.lo_qneg   = lo_d[W] ^ dneg;
        flags.hi_qneg   = hi_d[W] ^ dneg;
    end

endmodule

// ----- sv/rbst_div.sv -----
module rbst_div
    import rbst_pkg::*;
#(
    parameter int W = VALUE_WIDTH_DEF,
    parameter int F = FRACTION_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                qneg,
    input  logic [W-1:0]        nmag,
    input  logic [W-1:0]        dmag,
    output logic                done,
    output logic signed [W-1:0] quot
);

    localparam int STEPS = W + F;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);
    localparam logic [W:0] LIM_NEG = (W + 1)'(1) << (W - 1);
    localparam logic [W:0] LIM_POS = LIM_NEG - 1'b1;

    logic                busy_reg, busy_next;
    logic                fin_reg, fin_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [W-1:0]        rem_reg, rem_next;
    logic [STEPS-1:0]    dvd_reg, dvd_next;
    logic [W:0]          quo_reg, quo_next;
    logic                ovf_reg, ovf_next;
    logic                qneg_reg, qneg_next;
    logic [W-1:0]        dmag_reg, dmag_next;
    logic signed [W-1:0] quot_reg, quot_next;

    logic [W:0]   r_sh, r_sub;
    logic         ge;
    logic [W:0]   lim, mag;
    logic [W-1:0] mag_w;

    assign done = done_reg;
    assign quot = quot_reg;

    always_comb
    begin
        r_sh  = {rem_reg, dvd_reg[STEPS-1]};
        r_sub = r_sh - {1'b0, dmag_reg};
        ge    = (r_sh >= {1'b0, dmag_reg});
        lim   = qneg_reg ? LIM_NEG : LIM_POS;
        mag   = (ovf_reg || (quo_reg > lim)) ? lim : quo_reg;
        mag_w = mag[W-1:0];

        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = fin_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        qneg_next = qneg_reg;
        dmag_next = dmag_reg;
        quot_next = quot_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = {nmag, {F{1'b0}}};
            quo_next  = '0;
            ovf_next  = 1'b0;
            qneg_next = qneg;
            dmag_next = dmag;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? r_sub[W-1:0] : r_sh[W-1:0];
            dvd_next = dvd_reg << 1;
            quo_next = {quo_reg[W-1:0], ge};
            ovf_next = ovf_reg | quo_reg[W];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end

        if (fin_reg)
        begin
            quot_next = qneg_reg ? -mag_w : mag_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        ovf_reg  <= ovf_next;
        qneg_reg <= qneg_next;
        dmag_reg <= dmag_next;
        quot_reg <= quot_next;
    end

endmodule

// ----- sv/rbst_back.sv -----
module rbst_back
    import rbst_pkg::*;
#(
    parameter int W = VALUE_WIDTH_DEF,
    parameter int F = FRACTION_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  rbst_flags_t         q_flags,
    input  logic [W-1:0]        q_nmag_lo,
    input  logic [W-1:0]        q_nmag_hi,
    input  logic [W-1:0]        q_dmag,
    input  logic signed [W-1:0] q_istart,
    input  logic signed [W-1:0] q_iend,
    output logic                q_pop,
    input  logic                res_pop,
    output logic                res_valid,
    output logic                res_hit
);

    localparam logic signed [W-1:0] V_MAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0] V_MIN = {1'b1, {(W - 1){1'b0}}};

    bk_state_t           state_reg, state_next;
    rbst_flags_t         flags_reg;
    logic signed [W-1:0] istart_reg, iend_reg;
    logic signed [W-1:0] near_reg, near_next;
    logic signed [W-1:0] far_reg, far_next;
    logic signed [W-1:0] run_start_reg, run_start_next;
    logic signed [W-1:0] run_end_reg, run_end_next;
    logic                missed_reg, missed_next;
    logic                res_valid_reg, res_valid_next;
    logic                res_hit_reg, res_hit_next;

    logic                div_start;
    logic                done_lo, done_hi;
    logic signed [W-1:0] t_lo, t_hi;
    logic                out_free;
    logic                load_ord, narrow_en, check_en, emit;
    logic                axis_miss;

    rbst_div #(.W(W), .F(F)) u_div_lo (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .qneg  (q_flags.lo_qneg),
        .nmag  (q_nmag_lo),
        .dmag  (q_dmag),
        .done  (done_lo),
        .quot  (t_lo)
    );

    rbst_div #(.W(W), .F(F)) u_div_hi (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .qneg  (q_flags.hi_qneg),
        .nmag  (q_nmag_hi),
        .dmag  (q_dmag),
        .done  (done_hi),
        .quot  (t_hi)
    );

    assign out_free  = !res_valid_reg || res_pop;
    assign res_valid = res_valid_reg;
    assign res_hit   = res_hit_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_flags.dir_zero ? BK_ORDER : BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (done_lo)
                begin
                    state_next = BK_ORDER;
                end
            end
            BK_ORDER:  state_next = BK_NARROW;
            BK_NARROW: state_next = BK_CHECK;
            BK_CHECK:
            begin
                if (!flags_reg.last || out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        load_ord  = 1'b0;
        narrow_en = 1'b0;
        check_en  = 1'b0;
        case (state_reg)
            BK_IDLE:   q_pop     = q_valid;
            BK_DIV:    q_pop     = 1'b0;
            BK_ORDER:  load_ord  = 1'b1;
            BK_NARROW: narrow_en = 1'b1;
            BK_CHECK:  check_en  = !flags_reg.last || out_free;
            default:   q_pop     = 1'b0;
        endcase
        div_start = q_pop && !q_flags.dir_zero;
        emit      = check_en && flags_reg.last;
    end

    always_comb
    begin
        near_next      = near_reg;
        far_next       = far_reg;
        run_start_next = run_start_reg;
        run_end_next   = run_end_reg;
        missed_next    = missed_reg;
        res_hit_next   = res_hit_reg;
        res_valid_next = res_valid_reg && !res_pop;
        axis_miss      = flags_reg.dir_zero && flags_reg.zero_miss;

        if (load_ord)
        begin
            if (flags_reg.dir_zero)
            begin
                near_next = V_MIN;
                far_next  = V_MAX;
            end
            else
            begin
                near_next = (t_hi < t_lo) ? t_hi : t_lo;
                far_next  = (t_lo < t_hi) ? t_hi : t_lo;
            end
            if (flags_reg.first)
            begin
                run_start_next = istart_reg;
                run_end_next   = iend_reg;
                missed_next    = 1'b0;
            end
        end

        if (narrow_en)
        begin
            run_start_next = (run_start_reg < near_reg) ? near_reg : run_start_reg;
            run_end_next   = (far_reg < run_end_reg) ? far_reg : run_end_reg;
        end

        if (check_en)
        begin
            missed_next = missed_reg || axis_miss || !(run_start_reg < run_end_reg);
        end

        if (emit)
        begin
            res_valid_next = 1'b1;
            res_hit_next   = !missed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            run_start_reg <= '0;
            run_end_reg   <= '0;
            missed_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_start_reg <= run_start_next;
            run_end_reg   <= run_end_next;
            missed_reg    <= missed_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            flags_reg  <= q_flags;
            istart_reg <= q_istart;
            iend_reg   <= q_iend;
        end
        near_reg    <= near_next;
        far_reg     <= far_next;
        res_hit_reg <= res_hit_next;
    end

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        done_lo == done_hi)
        else $error("slab dividers out of step");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        done_lo |-> state_reg == BK_DIV)
        else $error("divider finished outside divide state");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> res_valid_reg)
        else $error("result lost after emit");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_CHECK) && flags_reg.last && res_valid_reg && !res_pop
        |=> state_reg == BK_CHECK && $stable(res_hit_reg))
        else $error("check stage left while result register busy");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == BK_DIV || state_reg == BK_ORDER)
        else $error("queue popped without starting an axis");

endmodule

// ----- test/ray_box_slab_test_unit_test.sv -----
`timescale 1ns / 1ps

module ray_box_slab_test_unit_test;
    import rbst_pkg::*;

    localparam int VW           = VALUE_WIDTH_DEF;
    localparam int FB           = FRACTION_BITS_DEF;
    localparam int ITEM_COUNT   = 850;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PRINT_LIMIT  = 20;

    localparam logic signed [VW-1:0] Q_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] Q_MIN = {1'b1, {(VW-1){1'b0}}};

    typedef struct packed {
        logic                 is_first;
        logic                 is_last;
        logic signed [VW-1:0] lo;
        logic signed [VW-1:0] hi;
        logic signed [VW-1:0] org;
        logic signed [VW-1:0] dir;
        logic signed [VW-1:0] t_start;
        logic signed [VW-1:0] t_end;
    } axis_item_t;

    typedef enum int {
        POP_STREAM,
        POP_COIN,
        POP_HOLD
    } pop_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic                 first_axis;
    logic                 last_axis;
    logic signed [VW-1:0] box_low;
    logic signed [VW-1:0] box_high;
    logic signed [VW-1:0] ray_origin;
    logic signed [VW-1:0] ray_dir;
    logic signed [VW-1:0] interval_start;
    logic signed [VW-1:0] interval_end;
    logic                 empty;
    logic                 pop;
    logic                 hit;

    axis_item_t           pending_axes[$];
    logic                 hit_expect[$];

    logic signed [VW-1:0] span_start = '0;
    logic signed [VW-1:0] span_end   = '0;
    logic                 span_missed = 1'b0;

    int        errors         = 0;
    int        axes_seen      = 0;
    int        zero_dir_axes  = 0;
    int        sat_quotients  = 0;
    int        results_seen   = 0;
    int        hits_seen      = 0;
    int        idle_cycles    = 0;
    int        burst_left     = 0;
    int        gap_left       = 0;
    int        pop_run        = 0;
    pop_mode_t pop_mode       = POP_STREAM;
    logic      in_xfer        = 1'b0;
    logic      expected_hit;

    ray_box_slab_test_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .first_axis     (first_axis),
        .last_axis      (last_axis),
        .box_low        (box_low),
        .box_high       (box_high),
        .ray_origin     (ray_origin),
        .ray_dir        (ray_dir),
        .interval_start (interval_start),
        .interval_end   (interval_end),
        .empty          (empty),
        .pop            (pop),
        .hit            (hit)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic logic signed [VW-1:0] slab_distance(
        input logic signed [VW-1:0] bound,
        input logic signed [VW-1:0] org,
        input logic signed [VW-1:0] dir
    );
        logic [VW:0]   diff;
        logic [VW:0]   diff_mag;
        logic [VW-1:0] dir_mag;
        logic [63:0]   quot;
        logic [63:0]   limit;
        logic          q_neg;
        diff     = {bound[VW-1], bound} - {org[VW-1], org};
        diff_mag = diff[VW] ? (~diff + 1'b1) : diff;
        dir_mag  = dir[VW-1] ? (~dir + 1'b1) : dir;
        q_neg    = diff[VW] ^ dir[VW-1];
        quot     = (64'(diff_mag) << FB) / 64'(dir_mag);
        limit    = q_neg ? (64'(1) << (VW - 1)) : ((64'(1) << (VW - 1)) - 64'(1));
        if (quot > limit)
        begin
            quot = limit;
            sat_quotients++;
        end
        if (q_neg)
            quot = ~quot + 64'(1);
        return quot[VW-1:0];
    endfunction

    function automatic void fold_axis(input axis_item_t a);
        logic signed [VW-1:0] lo;
        logic signed [VW-1:0] hi;
        logic signed [VW-1:0] org;
        logic signed [VW-1:0] dir;
        logic signed [VW-1:0] t_lo;
        logic signed [VW-1:0] t_hi;
        logic signed [VW-1:0] near_t;
        logic signed [VW-1:0] far_t;
        logic signed [VW-1:0] b_min;
        logic signed [VW-1:0] b_max;
        logic                 axis_miss;
        lo        = a.lo;
        hi        = a.hi;
        org       = a.org;
        dir       = a.dir;
        axis_miss = 1'b0;
        axes_seen++;
        if (a.is_first)
        begin
            span_start  = a.t_start;
            span_end    = a.t_end;
            span_missed = 1'b0;
        end
        if (dir == 0)
        begin
            zero_dir_axes++;
            b_min     = (hi < lo) ? hi : lo;
            b_max     = (hi < lo) ? lo : hi;
            axis_miss = (org < b_min) || (org > b_max);
            near_t    = Q_MIN;
            far_t     = Q_MAX;
        end
        else
        begin
            t_lo   = slab_distance(lo, org, dir);
            t_hi   = slab_distance(hi, org, dir);
            near_t = (t_hi < t_lo) ? t_hi : t_lo;
            far_t  = (t_hi < t_lo) ? t_lo : t_hi;
        end
        if (near_t > span_start)
            span_start = near_t;
        if (far_t < span_end)
            span_end = far_t;
        if (axis_miss || !(span_start < span_end))
            span_missed = 1'b1;
        if (a.is_last)
            hit_expect.push_back(!span_missed);
    endfunction

    function automatic logic signed [VW-1:0] fx(input int units);
        return units <<< FB;
    endfunction

    function automatic void add_axis(
        input logic                 is_first,
        input logic                 is_last,
        input logic signed [VW-1:0] lo,
        input logic signed [VW-1:0] hi,
        input logic signed [VW-1:0] org,
        input logic signed [VW-1:0] dir,
        input logic signed [VW-1:0] t_start,
        input logic signed [VW-1:0] t_end
    );
        pending_axes.push_back({is_first, is_last, lo, hi, org, dir, t_start, t_end});
    endfunction

    function automatic logic signed [VW-1:0] pick_value(input int spread);
        int v;
        case ($urandom_range(0, 15))
            0:       v = $urandom;
            1:       v = Q_MIN;
            2:       v = Q_MAX;
            3:       v = $urandom_range(0, 2) - 1;
            default: v = int'($urandom_range(0, 2 * spread)) - spread;
        endcase
        return v;
    endfunction

    function automatic void add_random_test();
        axis_item_t           a;
        int                   n_axes;
        int                   spread;
        int                   k;
        logic                 aimed;
        logic signed [VW-1:0] lo;
        logic signed [VW-1:0] hi;
        logic signed [VW-1:0] swap;
        logic signed [VW-1:0] mid;
        n_axes = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 3;
        spread = 1 << $urandom_range(8, 22);
        aimed  = 1'($urandom_range(0, 1));
        for (k = 0; k < n_axes; k++)
        begin
            lo = pick_value(spread);
            hi = lo + $urandom_range(0, spread);
            if ($urandom_range(0, 7) == 0)
            begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
            mid        = (lo >>> 1) + (hi >>> 1);
            a.is_first = (k == 0);
            a.is_last  = (k == n_axes - 1);
            a.lo       = lo;
            a.hi       = hi;
            a.org      = (aimed && $urandom_range(0, 7) != 0) ? mid : pick_value(spread);
            a.dir      = ($urandom_range(0, 7) == 0) ? '0 : pick_value(spread);
            a.t_start  = $urandom_range(0, 1) ? '0 : pick_value(spread);
            a.t_end    = $urandom_range(0, 1) ? Q_MAX : pick_value(spread << 4);
            pending_axes.push_back(a);
        end
    endfunction

    function automatic void add_noise_axis();
        int spread;
        spread = 1 << $urandom_range(4, 24);
        add_axis(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 pick_value(spread), pick_value(spread), pick_value(spread),
                 pick_value(spread), pick_value(spread), pick_value(spread));
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_xfer && burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            if (gap_left > 0 || pending_axes.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                push <= 1'b0;
            end
            else
            begin
                push           <= 1'b1;
                first_axis     <= pending_axes[0].is_first;
                last_axis      <= pending_axes[0].is_last;
                box_low        <= pending_axes[0].lo;
                box_high       <= pending_axes[0].hi;
                ray_origin     <= pending_axes[0].org;
                ray_dir        <= pending_axes[0].dir;
                interval_start <= pending_axes[0].t_start;
                interval_end   <= pending_axes[0].t_end;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pop_run == 0)
            begin
                pop_mode = pop_mode_t'($urandom_range(0, 2));
                pop_run  = $urandom_range(1, 40);
            end
            pop_run--;
            case (pop_mode)
                POP_STREAM: pop <= 1'b1;
                POP_COIN:   pop <= $urandom_range(0, 1);
                default:    pop <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        in_xfer <= rst_n && push && !full;
        if (rst_n)
        begin
            if (push && !full)
            begin
                fold_axis({first_axis, last_axis, box_low, box_high, ray_origin, ray_dir,
                           interval_start, interval_end});
                void'(pending_axes.pop_front());
            end
            if (pop && !empty)
            begin
                results_seen++;
                if (hit_expect.size() == 0)
                    report_mismatch($sformatf("result with none pending, hit=%b", hit));
                else
                begin
                    expected_hit = hit_expect.pop_front();
                    if (hit !== expected_hit)
                        report_mismatch($sformatf("result %0d: hit=%b, want %b",
                                                  results_seen, hit, expected_hit));
                end
                if (hit === 1'b1)
                    hits_seen++;
            end
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: %0d cycles without a transfer, %0d axes unsent, %0d owed",
                         idle_cycles, pending_axes.size(), hit_expect.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        first_axis     = 1'b0;
        last_axis      = 1'b0;
        box_low        = '0;
        box_high       = '0;
        ray_origin     = '0;
        ray_dir        = '0;
        interval_start = '0;
        interval_end   = '0;

        // axis before any first mark: empty reset interval
        add_axis(0, 1, fx(-1), fx(1), 0, fx(1), 0, 0);
        add_axis(1, 1, fx(2), fx(4), 0, fx(1), 0, fx(100));
        add_axis(1, 0, fx(1), fx(3), 0, fx(1), 0, fx(10));
        add_axis(0, 0, fx(-1), fx(1), 0, 0, fx(7), fx(-7));
        add_axis(0, 1, fx(2), fx(6), 0, fx(2), 0, 0);
        add_axis(1, 0, fx(1), fx(3), 0, fx(1), 0, fx(10));
        add_axis(0, 0, fx(5), fx(7), 0, fx(1), 0, 0);
        add_axis(0, 1, fx(1), fx(2), 0, 0, 0, 0);
        add_axis(1, 1, fx(1), fx(2), fx(1), 0, 0, fx(1));
        add_axis(1, 1, fx(1), fx(2), fx(3), 0, 0, fx(1));
        add_axis(1, 1, fx(2), fx(-2), 0, 0, 0, fx(1));
        add_axis(1, 1, fx(4), fx(2), 0, fx(1), 0, fx(10));
        add_axis(1, 1, fx(2), fx(4), 0, fx(-1), fx(-10), 0);
        add_axis(1, 1, Q_MIN, Q_MAX, 0, 1, Q_MIN, Q_MAX);
        add_axis(1, 1, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX);
        add_axis(1, 1, Q_MAX, 0, Q_MIN, -1, Q_MIN, Q_MAX);
        add_axis(1, 1, fx(-1), fx(1), 0, 0, fx(5), fx(5));
        add_axis(1, 1, fx(-1), fx(1), 0, 0, fx(6), fx(2));
        add_axis(1, 1, fx(2), fx(4), 0, fx(1), fx(4), fx(10));
        add_axis(1, 0, fx(1), fx(9), 0, fx(1), 0, fx(10));
        add_axis(1, 0, fx(-3), fx(3), fx(1), fx(-2), Q_MIN, Q_MAX);
        add_axis(0, 1, fx(-3), fx(3), fx(1), fx(2), 0, 0);
        add_axis(1, 1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        add_axis(1, 1, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        add_axis(1, 1, 0, 0, 0, 0, 0, 0);

        while (pending_axes.size() < ITEM_COUNT)
        begin
            if ($urandom_range(0, 7) == 0)
                add_noise_axis();
            else
                add_random_test();
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_axes.size() != 0 || hit_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d axis transfers, %0d with zero direction, %0d saturated.",
                 axes_seen, zero_dir_axes, sat_quotients);
        $display("Checked %0d slab test results: %0d hits, %0d misses, %0d mismatches.",
                 results_seen, hits_seen, results_seen - hits_seen, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
